### hdl/gfmpi_pkg.sv
// Shared types, constants and the GF(2^16) multiply function.
package gfmpi_pkg;

  localparam int unsigned W          = 16;
  localparam int unsigned NUM_ROUNDS = 16;
  localparam int unsigned POLY_W     = 6;

  // x^16 reduces to x^5 + x^3 + x + 1
  localparam logic [POLY_W-1:0] POLY_LOW = 6'h2B;
  localparam logic [W-1:0]      INV_EXP  = 16'hFFFE;
  localparam logic [W-1:0]      GF_ONE   = 16'h0001;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_MUL = 2'd0;
  localparam mode_t MODE_POW = 2'd1;
  localparam mode_t MODE_INV = 2'd2;
  localparam mode_t MODE_NOP = 2'd3;

  // Data carried from one cell to the next.
  typedef struct packed {
    logic [W-1:0] acc;
    logic [W-1:0] base;
    logic [W-1:0] expo;
  } lane_t;

  // Carry-less product, then two folds of the high half by the polynomial.
  function automatic logic [W-1:0] gf_mul(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [2*W-2:0]      p;
    logic [W-2:0]        h;
    logic [W+POLY_W-2:0] t;
    logic [POLY_W-2:0]   g;
    logic [W-1:0]        r;
    p = '0;
    for (int i = 0; i < W; i++) begin
      if (y[i]) p = p ^ ({{(W-1){1'b0}}, x} << i);
    end
    h = p[2*W-2:W];
    t = {{(POLY_W-1){1'b0}}, p[W-1:0]};
    for (int j = 0; j < POLY_W; j++) begin
      if (POLY_LOW[j]) t = t ^ ({{POLY_W{1'b0}}, h} << j);
    end
    g = t[W+POLY_W-2:W];
    r = t[W-1:0];
    for (int j = 0; j < POLY_W; j++) begin
      if (POLY_LOW[j]) r = r ^ ({{(W-POLY_W+1){1'b0}}, g} << j);
    end
    return r;
  endfunction

endpackage

### hdl/gfmpi_cell.sv
// One square-and-multiply round: consumes the low exponent bit and passes on.
module gfmpi_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  gfmpi_pkg::lane_t in_lane,
  output logic            out_valid,
  output gfmpi_pkg::lane_t out_lane
);

  gfmpi_pkg::lane_t lane_next;

  always_comb begin
    lane_next.acc  = in_lane.expo[0] ? gfmpi_pkg::gf_mul(in_lane.acc, in_lane.base)
                                     : in_lane.acc;
    lane_next.base = gfmpi_pkg::gf_mul(in_lane.base, in_lane.base);
    lane_next.expo = {1'b0, in_lane.expo[gfmpi_pkg::W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_lane <= lane_next;
  end

endmodule

### hdl/gf2_16_mul_pow_inv_unit.sv
// Top level: GF(2^16) multiply / power / inverse on a chain of round cells.
//
//  channel   signals                          direction  handshake
//  command   start, mode, operand_a, operand_b  in       beat when start & !busy
//  result    done, result                      out       beat when done (no stall)
//
// Every beat enters the first cell and moves through the 16 registered
// cells in order, one exponent bit each; done is the last cell's valid bit.
// A new command beat can be taken every cycle while rst is low; the chain
// has 16 rounds, two field multipliers per cell.
// Reset clears every cell's valid bit; busy is high only while rst is high.
// The receiver cannot stall: each result shows for one cycle with done.
module gf2_16_mul_pow_inv_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               mode,
  input  logic [gfmpi_pkg::W-1:0]  operand_a,
  input  logic [gfmpi_pkg::W-1:0]  operand_b,
  output logic                     done,
  output logic [gfmpi_pkg::W-1:0]  result
);

  localparam int unsigned N = gfmpi_pkg::NUM_ROUNDS;

  logic             accept;
  gfmpi_pkg::lane_t init_lane;
  logic             valid_chain [N+1];
  gfmpi_pkg::lane_t lane_chain  [N+1];

  assign busy   = rst;
  assign accept = start & ~busy;

  // Every mode is cast as acc * base^expo.
  always_comb begin
    init_lane.base = operand_a;
    case (mode)
      gfmpi_pkg::MODE_MUL: begin
        init_lane.acc  = operand_b;
        init_lane.expo = gfmpi_pkg::GF_ONE;
      end
      gfmpi_pkg::MODE_POW: begin
        init_lane.acc  = gfmpi_pkg::GF_ONE;
        init_lane.expo = operand_b;
      end
      gfmpi_pkg::MODE_INV: begin
        init_lane.acc  = gfmpi_pkg::GF_ONE;
        init_lane.expo = gfmpi_pkg::INV_EXP;
      end
      default: begin
        init_lane.acc  = '0;
        init_lane.expo = '0;
      end
    endcase
  end

  assign valid_chain[0] = accept;
  assign lane_chain[0]  = init_lane;

  for (genvar k = 0; k < N; k++) begin : g_cell
    gfmpi_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_chain[k]),
      .in_lane   (lane_chain[k]),
      .out_valid (valid_chain[k+1]),
      .out_lane  (lane_chain[k+1])
    );
  end

  assign done   = valid_chain[N];
  assign result = lane_chain[N].acc;

  a_done_after_accept : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##16 done) else $error("missing done after command beat");

  a_no_spurious_done : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 16)) else $error("done without command beat");

  a_unused_mode_zero : assert property (@(posedge clk) disable iff (rst)
    (accept && mode == gfmpi_pkg::MODE_NOP) |-> ##16 (result == '0))
    else $error("unused mode gave nonzero result");

  a_zero_exp_one : assert property (@(posedge clk) disable iff (rst)
    (accept && mode == gfmpi_pkg::MODE_POW && operand_b == '0)
      |-> ##16 (result == gfmpi_pkg::GF_ONE))
    else $error("zero exponent did not give one");

  a_inv_zero : assert property (@(posedge clk) disable iff (rst)
    (accept && mode == gfmpi_pkg::MODE_INV && operand_a == '0) |-> ##16 (result == '0))
    else $error("inverse of zero not zero");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the GF(2^16) multiply / power / inverse unit.
module tb_top;

  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned RANDOM_ITEMS = 1728;
  localparam int unsigned NUM_PHASES   = 3;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    gfmpi_pkg::mode_t       op;
    logic [gfmpi_pkg::W-1:0] a;
    logic [gfmpi_pkg::W-1:0] b;
    logic                    typed;
    logic [gfmpi_pkg::W-1:0] value;
  } gf_cmd_row_t;

  // Directed commands: value is used as-is where typed is set.
  localparam gf_cmd_row_t DIRECTED_CMDS [22] = '{
    '{gfmpi_pkg::MODE_MUL, 16'h0000, 16'hFFFF, 1'b1, 16'h0000},
    '{gfmpi_pkg::MODE_MUL, 16'hFFFF, 16'h0000, 1'b1, 16'h0000},
    '{gfmpi_pkg::MODE_MUL, 16'h0001, 16'hBEEF, 1'b1, 16'hBEEF},
    '{gfmpi_pkg::MODE_MUL, 16'h8000, 16'h0002, 1'b1, 16'h002B},
    '{gfmpi_pkg::MODE_MUL, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
    '{gfmpi_pkg::MODE_MUL, 16'h8000, 16'h8000, 1'b0, 16'h0000},
    '{gfmpi_pkg::MODE_MUL, 16'h5555, 16'hAAAA, 1'b0, 16'h0000},
    '{gfmpi_pkg::MODE_POW, 16'h0000, 16'h0000, 1'b1, 16'h0001},
    '{gfmpi_pkg::MODE_POW, 16'h1234, 16'h0000, 1'b1, 16'h0001},
    '{gfmpi_pkg::MODE_POW, 16'h0000, 16'h0005, 1'b1, 16'h0000},
    '{gfmpi_pkg::MODE_POW, 16'hABCD, 16'h0001, 1'b1, 16'hABCD},
    '{gfmpi_pkg::MODE_POW, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
    '{gfmpi_pkg::MODE_POW, 16'h0002, 16'h0010, 1'b0, 16'h0000},
    '{gfmpi_pkg::MODE_POW, 16'h8001, 16'h8000, 1'b0, 16'h0000},
    '{gfmpi_pkg::MODE_POW, 16'h0003, 16'hFFFF, 1'b0, 16'h0000},
    '{gfmpi_pkg::MODE_INV, 16'h0000, 16'hFFFF, 1'b1, 16'h0000},
    '{gfmpi_pkg::MODE_INV, 16'h0001, 16'h0000, 1'b1, 16'h0001},
    '{gfmpi_pkg::MODE_INV, 16'hFFFF, 16'h1234, 1'b0, 16'h0000},
    '{gfmpi_pkg::MODE_INV, 16'h0002, 16'hFFFF, 1'b0, 16'h0000},
    '{gfmpi_pkg::MODE_INV, 16'h8000, 16'h0000, 1'b0, 16'h0000},
    '{gfmpi_pkg::MODE_NOP, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000},
    '{gfmpi_pkg::MODE_NOP, 16'h0000, 16'h0000, 1'b1, 16'h0000}
  };

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [1:0]              mode;
  logic [gfmpi_pkg::W-1:0] operand_a;
  logic [gfmpi_pkg::W-1:0] operand_b;
  logic                    done;
  logic [gfmpi_pkg::W-1:0] result;

  logic [gfmpi_pkg::W-1:0] cmd_result;       // expected result of the command on the bus
  logic [gfmpi_pkg::W-1:0] pending_results[$];
  logic [gfmpi_pkg::W-1:0] want;
  int unsigned  cycle_count;
  int unsigned  fail_count;
  int unsigned  report_count;
  int unsigned  checked_count;
  int unsigned  mode_seen[4];

  gf2_16_mul_pow_inv_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .done      (done),
    .result    (result)
  );

  // Shift-and-add product, folding x^16 back in as the low polynomial terms.
  function automatic logic [gfmpi_pkg::W-1:0] field_product(logic [gfmpi_pkg::W-1:0] x,
                                                           logic [gfmpi_pkg::W-1:0] y);
    logic [gfmpi_pkg::W-1:0] acc;
    logic [gfmpi_pkg::W-1:0] sh;
    acc = '0;
    sh  = x;
    for (int i = 0; i < gfmpi_pkg::W; i++) begin
      if (y[i]) acc = acc ^ sh;
      sh = {sh[gfmpi_pkg::W-2:0], 1'b0}
           ^ (sh[gfmpi_pkg::W-1]
              ? {{(gfmpi_pkg::W-gfmpi_pkg::POLY_W){1'b0}}, gfmpi_pkg::POLY_LOW} : '0);
    end
    return acc;
  endfunction

  function automatic logic [gfmpi_pkg::W-1:0] field_power(logic [gfmpi_pkg::W-1:0] x,
                                                         logic [gfmpi_pkg::W-1:0] e);
    logic [gfmpi_pkg::W-1:0] acc;
    logic [gfmpi_pkg::W-1:0] sq;
    acc = gfmpi_pkg::GF_ONE;
    sq  = x;
    for (int i = 0; i < gfmpi_pkg::NUM_ROUNDS; i++) begin
      if (e[i]) acc = field_product(acc, sq);
      sq = field_product(sq, sq);
    end
    return acc;
  endfunction

  function automatic logic [gfmpi_pkg::W-1:0] field_op_result(gfmpi_pkg::mode_t op,
                                                             logic [gfmpi_pkg::W-1:0] a,
                                                             logic [gfmpi_pkg::W-1:0] b);
    case (op)
      gfmpi_pkg::MODE_MUL: return field_product(a, b);
      gfmpi_pkg::MODE_POW: return field_power(a, b);
      gfmpi_pkg::MODE_INV: return field_power(a, gfmpi_pkg::INV_EXP);
      default:             return '0;
    endcase
  endfunction

  // Operands biased toward zero, one, all-ones, single-bit and small values.
  function automatic logic [gfmpi_pkg::W-1:0] pick_element();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return gfmpi_pkg::GF_ONE;
      2:       return 16'hFFFF;
      3:       return 16'h0001 << $urandom_range(gfmpi_pkg::W-1);
      4:       return gfmpi_pkg::W'($urandom_range(15));
      default: return gfmpi_pkg::W'($urandom);
    endcase
  endfunction

  function automatic gfmpi_pkg::mode_t pick_mode();
    int unsigned r;
    r = $urandom_range(19);
    if (r < 6)  return gfmpi_pkg::MODE_MUL;
    if (r < 12) return gfmpi_pkg::MODE_POW;
    if (r < 19) return gfmpi_pkg::MODE_INV;
    return gfmpi_pkg::MODE_NOP;
  endfunction

  // Present one command at the falling edge and hold it until the beat.
  task automatic send_cmd(gfmpi_pkg::mode_t op, logic [gfmpi_pkg::W-1:0] a,
                          logic [gfmpi_pkg::W-1:0] b, logic [gfmpi_pkg::W-1:0] expected);
    @(negedge clk);
    start      <= 1'b1;
    mode       <= op;
    operand_a  <= a;
    operand_b  <= b;
    cmd_result = expected;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random idle cycles with junk on the command fields.
  task automatic sender_idle(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start     <= 1'b0;
      mode      <= 2'($urandom);
      operand_a <= gfmpi_pkg::W'($urandom);
      operand_b <= gfmpi_pkg::W'($urandom);
      @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD/2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Scoreboard: record each command beat, check each result beat in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        pending_results.push_back(cmd_result);
        mode_seen[mode]++;
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("[%0d] unexpected result beat: result=%04h", cycle_count, result);
          end
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (result !== want) begin
            fail_count++;
            if (report_count < MAX_REPORTS) begin
              report_count++;
              $display("[%0d] result mismatch: expected %04h, got %04h",
                       cycle_count, want, result);
            end
          end
        end
      end
    end
  end

  initial begin
    int unsigned             idle_pct [NUM_PHASES];
    gf_cmd_row_t             row;
    gfmpi_pkg::mode_t        op;
    logic [gfmpi_pkg::W-1:0] a;
    logic [gfmpi_pkg::W-1:0] b;
    idle_pct  = '{0, 76, 11};
    rst       <= 1'b1;
    start     <= 1'b0;
    mode      <= gfmpi_pkg::MODE_MUL;
    operand_a <= '0;
    operand_b <= '0;
    cmd_result = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_CMDS[i]) begin
      row = DIRECTED_CMDS[i];
      send_cmd(row.op, row.a, row.b,
               row.typed ? row.value : field_op_result(row.op, row.a, row.b));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
        op = pick_mode();
        a  = pick_element();
        b  = pick_element();
        // idle percentage applies in bursts so some stretches run back to back
        if ((n % 64) < 48) sender_idle(idle_pct[p]);
        send_cmd(op, a, b, field_op_result(op, a, b));
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d multiply, %0d power, %0d inverse, %0d unused mode",
             checked_count, mode_seen[gfmpi_pkg::MODE_MUL], mode_seen[gfmpi_pkg::MODE_POW],
             mode_seen[gfmpi_pkg::MODE_INV], mode_seen[gfmpi_pkg::MODE_NOP]);
    $display("Idle phases: back-to-back, sender idle 76%%, sender idle 11%%; %0d failures",
             fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
